>>> design/salc_pkg.sv
package salc_pkg;

  // link event codes
  localparam logic [2:0] CMD_PACKET = 3'd0;
  localparam logic [2:0] CMD_ACK    = 3'd1;
  localparam logic [2:0] CMD_NAK    = 3'd2;
  localparam logic [2:0] CMD_ENQ    = 3'd3;
  localparam logic [2:0] CMD_CANCEL = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;
  localparam logic [2:0] CMD_SEND   = 3'd6;
  localparam logic [2:0] CMD_ABORT  = 3'd7;

  // control frame codes
  localparam logic [2:0] FR_NONE    = 3'd0;
  localparam logic [2:0] FR_ACKNUM  = 3'd1;
  localparam logic [2:0] FR_BAREACK = 3'd2;
  localparam logic [2:0] FR_NAK     = 3'd3;
  localparam logic [2:0] FR_CANEOT  = 3'd4;

  // configuration space
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;
  localparam logic        REG_TIMEOUT  = 1'b0;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] seq_number;
    logic       crc_ok;
  } item_t;

  typedef struct packed {
    logic [2:0] control_frame;
    logic       control_seq;
    logic       send_packet;
    logic       packet_seq;
    logic       deliver;
    logic       write_done;
    logic       write_busy;
    logic       stopped;
  } result_t;

endpackage

>>> design/salc_ifs.sv
interface salc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] seq_number;
  logic       crc_ok;

  modport source (output valid, command, seq_number, crc_ok, input ready);
  modport sink (input valid, command, seq_number, crc_ok, output ready);
endinterface

interface salc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] control_frame;
  logic       control_seq;
  logic       send_packet;
  logic       packet_seq;
  logic       deliver;
  logic       write_done;
  logic       write_busy;
  logic       stopped;

  modport source (output valid, control_frame, control_seq, send_packet, packet_seq,
                  deliver, write_done, write_busy, stopped, input ready);
  modport sink (input valid, control_frame, control_seq, send_packet, packet_seq,
                deliver, write_done, write_busy, stopped, output ready);
endinterface

>>> design/salc_engine.sv
module salc_engine
  import salc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  item_t      item,
  input  logic [7:0] timeout_ticks,
  output result_t    result
);

  logic       receive_seq, receive_seq_next;
  logic       send_seq, send_seq_next;
  logic       awaiting_ack, awaiting_ack_next;
  logic       packet_outstanding, packet_outstanding_next;
  logic [7:0] retry_countdown, retry_countdown_next;
  logic       link_down, link_down_next;
  logic [7:0] reload;

  // a zero timeout acts as one tick
  assign reload = (timeout_ticks == 8'd0) ? 8'd1 : timeout_ticks;

  always_comb begin
    receive_seq_next        = receive_seq;
    send_seq_next           = send_seq;
    awaiting_ack_next       = awaiting_ack;
    packet_outstanding_next = packet_outstanding;
    retry_countdown_next    = retry_countdown;
    link_down_next          = link_down;
    result                  = '0;
    if (!link_down) begin
      unique case (item.command)
        CMD_PACKET: begin
          if (!item.crc_ok) begin
            result.control_frame = FR_NAK;
          end else if (item.seq_number == {7'd0, receive_seq}) begin
            result.control_frame = FR_ACKNUM;
            result.control_seq   = receive_seq;
            result.deliver       = 1'b1;
            receive_seq_next     = ~receive_seq;
          end else begin
            result.control_frame = FR_ACKNUM;
            result.control_seq   = ~receive_seq;
          end
          if (awaiting_ack) begin
            retry_countdown_next = reload;
          end
        end
        CMD_ACK: begin
          if (packet_outstanding && item.seq_number == {7'd0, send_seq}) begin
            result.write_done       = 1'b1;
            send_seq_next           = ~send_seq;
            awaiting_ack_next       = 1'b0;
            packet_outstanding_next = 1'b0;
            retry_countdown_next    = 8'd0;
          end
        end
        CMD_NAK: begin
          if (packet_outstanding) begin
            result.send_packet   = 1'b1;
            result.packet_seq    = send_seq;
            awaiting_ack_next    = 1'b1;
            retry_countdown_next = reload;
          end
        end
        CMD_ENQ: begin
          result.control_frame = FR_BAREACK;
        end
        CMD_TICK: begin
          if (awaiting_ack) begin
            if (retry_countdown[7:1] == 7'd0) begin
              result.send_packet   = 1'b1;
              result.packet_seq    = send_seq;
              retry_countdown_next = reload;
            end else begin
              retry_countdown_next = retry_countdown - 8'd1;
            end
          end
        end
        CMD_SEND: begin
          if (packet_outstanding) begin
            result.write_busy = 1'b1;
          end else begin
            result.send_packet      = 1'b1;
            result.packet_seq       = send_seq;
            packet_outstanding_next = 1'b1;
            awaiting_ack_next       = 1'b1;
            retry_countdown_next    = reload;
          end
        end
        CMD_CANCEL, CMD_ABORT: begin
          result.control_frame    = FR_CANEOT;
          link_down_next          = 1'b1;
          awaiting_ack_next       = 1'b0;
          packet_outstanding_next = 1'b0;
          retry_countdown_next    = 8'd0;
        end
        default: begin
          result.control_frame = FR_NONE;
        end
      endcase
    end
    result.stopped = link_down_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_seq        <= 1'b0;
      send_seq           <= 1'b0;
      awaiting_ack       <= 1'b0;
      packet_outstanding <= 1'b0;
      retry_countdown    <= 8'd0;
      link_down          <= 1'b0;
    end else if (accept) begin
      receive_seq        <= receive_seq_next;
      send_seq           <= send_seq_next;
      awaiting_ack       <= awaiting_ack_next;
      packet_outstanding <= packet_outstanding_next;
      retry_countdown    <= retry_countdown_next;
      link_down          <= link_down_next;
    end
  end

endmodule

>>> design/stop_and_wait_link_controller_core.sv
// channel   role     payload
// link      sink     command, seq_number, crc_ok
// result    source   control_frame, control_seq, send_packet, packet_seq,
//                    deliver, write_done, write_busy, stopped
// apb       slave    timeout_ticks at byte address 0
//
// one item per cycle while the skid register is free; each accepted item's result is registered
// the state update and result decode are combinational, ahead of the result register
// a skid register behind the result register keeps link ready for one stalled result
// rst is synchronous and active high: sequence bits, countdown and link state clear,
// timeout_ticks returns to 3
module stop_and_wait_link_controller_core
  import salc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  salc_in_if.sink              link,
  salc_out_if.source           result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  logic [7:0] timeout_ticks;
  item_t      item;
  result_t    step_result;
  logic       accept;
  logic       pop;

  // result register and skid register
  logic       out_valid;
  result_t    out_data;
  logic       skid_valid;
  result_t    skid_data;

  // apb register: only index zero exists, paddr[2] selects the index
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
      timeout_ticks <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT) begin
      prdata = {{(PDATA_W-8){1'b0}}, timeout_ticks};
    end
  end

  // link handshake: room as long as the skid register is free
  assign link.ready = !skid_valid;
  assign accept     = link.valid && link.ready;
  assign pop        = out_valid && result.ready;

  assign item.command    = link.command;
  assign item.seq_number = link.seq_number;
  assign item.crc_ok     = link.crc_ok;

  salc_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .result        (step_result)
  );

  // output staging: fresh results go to the result register when it frees up and the skid
  // register is empty, otherwise they park in the skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= step_result;
      end else begin
        out_data  <= step_result;
      end
    end else if (accept) begin
      skid_data <= step_result;
    end
  end

  assign result.valid         = out_valid;
  assign result.control_frame = out_data.control_frame;
  assign result.control_seq   = out_data.control_seq;
  assign result.send_packet   = out_data.send_packet;
  assign result.packet_seq    = out_data.packet_seq;
  assign result.deliver       = out_data.deliver;
  assign result.write_done    = out_data.write_done;
  assign result.write_busy    = out_data.write_busy;
  assign result.stopped       = out_data.stopped;

  // a parked result always has an older one ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the result register is empty");

  // a stalled result with a full skid must keep both and take nothing new
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !result.ready) |=> (skid_valid && out_valid && $stable(out_data)))
    else $error("stalled results changed");

  // a stopped link only reports the cancel frame or nothing
  a_stopped_frame: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.stopped) |->
      (result.control_frame == FR_NONE || result.control_frame == FR_CANEOT))
    else $error("stopped link sent a frame other than cancel");

  // a refused send request never also starts a transmission
  a_busy_alone: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.write_busy) |-> (!result.send_packet && !result.write_done))
    else $error("busy result carries a send or completion");

endmodule
